[sv/ptm_pkg.sv]
// Shared types and constants of the phase timing monitor.
// No dependencies; imported by all ptm modules.
`default_nettype none
package ptm_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_LOOP_PERIOD = 1'd0,
        REG_AVG_SHIFT   = 1'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_AVG,
        ST_JIT,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_back_state;

    // Classified request handed from front to back
    typedef struct packed {
        t_op         op;
        logic        ph_ok;
        logic [1:0]  phase;
        logic [31:0] now_us;
        logic [31:0] budget_us;
    } t_req;

    typedef struct packed {
        logic        valid;
        t_reg_idx    index;
        logic [15:0] data;
    } t_cfg_wr;

    localparam logic [9:0]  LOAD_FULL      = 10'd1000;
    localparam int          LOAD_Q_BITS    = 10;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;
    localparam logic [15:0] PERIOD_RESET   = 16'd1000;
    localparam logic [3:0]  SHIFT_RESET    = 4'd4;

endpackage
`default_nettype wire

[sv/phase_timing_monitor_top.sv]
// Top level of the phase timing monitor: front queue plus back sequencer.
// Depends on ptm_pkg, ptm_front, ptm_back.
//
//  channel | direction | handshake            | payload
//  in      | request   | i_in_valid/o_in_stall | op, phase, now_us, budget_us
//  out     | result    | o_out_valid/i_out_stall | statistics, load, all_ok
//  cfg     | write     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A request steps through idle, exec, load and out (begin, clear, read), with avg and jit
// added for an end on a valid phase; unless load saturates, the one-bit-per-cycle load divider runs before out.
// A two-entry queue keeps accepting requests while the back end or output stalls, until it is full.
// Synchronous active-low reset; config registers return to 1000 us and shift 4.
`default_nettype none
module phase_timing_monitor_top #(
    parameter int PHASES        = 4,
    parameter int AVG_FRAC_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [1:0]   i_op,
    input  wire [1:0]   i_phase,
    input  wire [31:0]  i_now_us,
    input  wire [31:0]  i_budget_us,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_max_us,
    output logic [23:0] o_avg_us,
    output logic [31:0] o_max_jitter_us,
    output logic [15:0] o_miss_count,
    output logic        o_over_budget,
    output logic [15:0] o_sample_count,
    output logic [9:0]  o_load_permille,
    output logic        o_all_ok,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [15:0]  i_cfg_data
);
    import ptm_pkg::*;

    logic    w_q_valid, w_q_pop;
    t_req    w_q_req;
    t_cfg_wr w_cfg;

    assign o_cfg_ready = 1'b1;
    always_comb begin
        w_cfg.valid = i_cfg_valid;
        w_cfg.index = t_reg_idx'(i_cfg_index);
        w_cfg.data  = i_cfg_data;
    end

    ptm_front #(.PHASES(PHASES)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_op, .i_phase, .i_now_us, .i_budget_us,
        .o_q_valid(w_q_valid), .o_q_req(w_q_req), .i_q_pop(w_q_pop)
    );

    ptm_back #(.PHASES(PHASES), .AVG_FRAC_BITS(AVG_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cfg(w_cfg),
        .i_q_valid(w_q_valid), .i_q_req(w_q_req), .o_q_pop(w_q_pop),
        .o_out_valid, .i_out_stall,
        .o_max_us, .o_avg_us, .o_max_jitter_us, .o_miss_count,
        .o_over_budget, .o_sample_count, .o_load_permille, .o_all_ok
    );

`ifndef SYNTHESIS
    a_load_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_load_permille <= 10'd1000)
        else $error("load above 1000 permille");
    a_ok_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_over_budget) |-> !o_all_ok)
        else $error("all_ok set with phase over budget");
    a_miss_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_miss_count != 16'd0) |-> o_over_budget)
        else $error("misses counted without over-budget flag");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

[sv/ptm_front.sv]
// Front end: accepts requests, classifies op and phase, queues them.
// Depends on ptm_pkg.
`default_nettype none
module ptm_front #(
    parameter int PHASES = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire [1:0]         i_op,
    input  wire [1:0]         i_phase,
    input  wire [31:0]        i_now_us,
    input  wire [31:0]        i_budget_us,
    output logic              o_q_valid,
    output ptm_pkg::t_req     o_q_req,
    input  wire               i_q_pop
);
    import ptm_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_req;
    logic       w_push;

    always_comb begin
        w_req.op        = t_op'(i_op);
        w_req.ph_ok     = (32'(i_phase) < PHASES);
        w_req.phase     = i_phase;
        w_req.now_us    = i_now_us;
        w_req.budget_us = i_budget_us;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_req    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_req;
    end

endmodule
`default_nettype wire

[sv/ptm_back.sv]
// Back end: phase statistics, sequenced update, load divider, result register.
// Depends on ptm_pkg.
`default_nettype none
module ptm_back #(
    parameter int PHASES        = 4,
    parameter int AVG_FRAC_BITS = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ptm_pkg::t_cfg_wr  i_cfg,
    input  wire               i_q_valid,
    input  ptm_pkg::t_req     i_q_req,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [31:0]       o_max_us,
    output logic [23:0]       o_avg_us,
    output logic [31:0]       o_max_jitter_us,
    output logic [15:0]       o_miss_count,
    output logic              o_over_budget,
    output logic [15:0]       o_sample_count,
    output logic [9:0]        o_load_permille,
    output logic              o_all_ok
);
    import ptm_pkg::*;

    localparam int IW = (PHASES > 1) ? $clog2(PHASES) : 1;

    t_back_state r_state, n_state;

    logic [15:0] r_period;
    logic [3:0]  r_shift;

    logic [31:0] r_start [PHASES];
    logic [31:0] r_maxe  [PHASES];
    logic [31:0] r_avg   [PHASES];
    logic [31:0] r_jit   [PHASES];
    logic [15:0] r_miss  [PHASES];
    logic [PHASES-1:0] r_exc;
    logic [15:0] r_win;

    t_req        r_cur;
    logic [31:0] r_elap;
    logic [15:0] r_rem;
    logic [9:0]  r_quo;
    logic [3:0]  r_dcnt;
    logic [9:0]  r_load;

    logic [IW-1:0] w_idx;
    logic [31:0]   w_sample, w_avg_old, w_avg_new, w_avg_int, w_jit, w_last_int;
    logic signed [32:0] w_diff, w_step;
    logic [32:0]   w_sum;
    logic [16:0]   w_trial;
    logic          w_ge, w_out_load, w_end;

    assign w_idx = IW'(r_cur.phase);
    assign w_end = (r_cur.op == OP_END) && r_cur.ph_ok;

    // Exponential average: arithmetic shift of the signed difference
    always_comb begin
        w_avg_old = r_avg[w_idx];
        w_sample  = r_elap << AVG_FRAC_BITS;
        w_diff    = $signed({1'b0, w_sample}) - $signed({1'b0, w_avg_old});
        w_step    = w_diff >>> r_shift;
        w_sum     = 33'(w_avg_old) + 33'(w_step);
        w_avg_new = (w_avg_old == 32'd0) ? w_sample : w_sum[31:0];
        w_avg_int = r_avg[w_idx] >> AVG_FRAC_BITS;
        w_jit     = (r_elap > w_avg_int) ? (r_elap - w_avg_int) : (w_avg_int - r_elap);
        w_last_int = r_avg[PHASES-1] >> AVG_FRAC_BITS;
        w_trial   = {r_rem, r_quo[LOAD_Q_BITS-1]};
        w_ge      = (w_trial >= {1'b0, r_period});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = w_end ? ST_AVG : ST_LOAD;
            ST_AVG:  n_state = ST_JIT;
            ST_JIT:  n_state = ST_LOAD;
            ST_LOAD: n_state = (w_last_int >= 32'(r_period)) ? ST_OUT : ST_DIV;
            ST_DIV:  if (r_dcnt == 4'd0) n_state = ST_OUT;
            ST_OUT:  if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
        w_out_load = (r_state == ST_OUT) && (!o_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_out_valid <= 1'b0;
            r_period    <= PERIOD_RESET;
            r_shift     <= SHIFT_RESET;
            r_exc       <= '0;
            r_win       <= '0;
            for (int i = 0; i < PHASES; i++) begin
                r_start[i] <= '0;
                r_maxe[i]  <= '0;
                r_avg[i]   <= '0;
                r_jit[i]   <= '0;
                r_miss[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_LOOP_PERIOD: r_period <= i_cfg.data;
                    REG_AVG_SHIFT:   r_shift  <= i_cfg.data[3:0];
                    default: ;
                endcase
            end
            if (w_out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (r_state == ST_EXEC) begin
                if (r_cur.op == OP_BEGIN && r_cur.ph_ok) begin
                    r_start[w_idx] <= r_cur.now_us;
                end
                if (r_cur.op == OP_CLEAR) begin
                    r_exc <= '0;
                    r_win <= '0;
                    for (int i = 0; i < PHASES; i++) begin
                        r_start[i] <= '0;
                        r_maxe[i]  <= '0;
                        r_avg[i]   <= '0;
                        r_jit[i]   <= '0;
                        r_miss[i]  <= '0;
                    end
                end
            end
            if (r_state == ST_AVG) begin
                r_avg[w_idx] <= w_avg_new;
                if (r_elap > r_maxe[w_idx]) r_maxe[w_idx] <= r_elap;
                if (r_elap > r_cur.budget_us) begin
                    r_exc[w_idx] <= 1'b1;
                    if (r_miss[w_idx] != CNT_MAX) r_miss[w_idx] <= r_miss[w_idx] + 16'd1;
                end
                if (32'(r_cur.phase) == PHASES - 1 && r_win != CNT_MAX) begin
                    r_win <= r_win + 16'd1;
                end
            end
            if (r_state == ST_JIT && w_jit > r_jit[w_idx]) begin
                r_jit[w_idx] <= w_jit;
            end
        end
    end

    // Datapath registers without reset
    logic [25:0] w_num;
    assign w_num = 26'(w_last_int[15:0]) * 26'(LOAD_FULL);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cur <= i_q_req;
        if (r_state == ST_EXEC) r_elap <= r_cur.now_us - r_start[w_idx];
        if (r_state == ST_LOAD) begin
            // quotient fits 10 bits, so the top bits seed the remainder
            r_load <= LOAD_FULL;
            r_rem  <= w_num[25:LOAD_Q_BITS];
            r_quo  <= w_num[LOAD_Q_BITS-1:0];
            r_dcnt <= 4'(LOAD_Q_BITS - 1);
        end
        if (r_state == ST_DIV) begin
            r_rem  <= w_ge ? 16'(w_trial - {1'b0, r_period}) : w_trial[15:0];
            r_quo  <= {r_quo[LOAD_Q_BITS-2:0], w_ge};
            r_dcnt <= r_dcnt - 4'd1;
            if (r_dcnt == 4'd0) r_load <= {r_quo[LOAD_Q_BITS-2:0], w_ge};
        end
        if (w_out_load) begin
            o_max_us        <= r_cur.ph_ok ? r_maxe[w_idx] : 32'd0;
            o_avg_us        <= r_cur.ph_ok ? w_avg_int[23:0] : 24'd0;
            o_max_jitter_us <= r_cur.ph_ok ? r_jit[w_idx] : 32'd0;
            o_miss_count    <= r_cur.ph_ok ? r_miss[w_idx] : 16'd0;
            o_over_budget   <= r_cur.ph_ok && r_exc[w_idx];
            o_sample_count  <= r_win;
            o_load_permille <= r_load;
            o_all_ok        <= (r_exc == '0);
        end
    end

endmodule
`default_nettype wire
